>>> rtl/mbet_pkg.sv
// Shared types and constants for the Mandelbrot escape-time block.
package mbet_pkg;

  localparam int DATA_W  = 32;
  localparam int PROD_W  = 64;
  localparam int COUNT_W = 16;
  localparam int DIM_W   = 13;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_ORIGIN_REAL    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_ORIGIN_IMAG    = 3'd1;
  localparam logic [INDEX_W-1:0] REG_STEP_REAL      = 3'd2;
  localparam logic [INDEX_W-1:0] REG_STEP_IMAG      = 3'd3;
  localparam logic [INDEX_W-1:0] REG_ITERATION_LIMIT = 3'd4;
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH    = 3'd5;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT   = 3'd6;

  localparam logic signed [DATA_W-1:0] RST_ORIGIN_REAL = -32'sd536870912;
  localparam logic signed [DATA_W-1:0] RST_ORIGIN_IMAG = -32'sd536870912;
  localparam logic signed [DATA_W-1:0] RST_STEP_REAL   = 32'sd1677722;
  localparam logic signed [DATA_W-1:0] RST_STEP_IMAG   = 32'sd1677722;
  localparam logic [COUNT_W-1:0]       RST_ITER_LIMIT  = 16'd40;
  localparam logic [DIM_W-1:0]         RST_IMAGE_WIDTH = 13'd640;
  localparam logic [DIM_W-1:0]         RST_IMAGE_HEIGHT = 13'd480;

  typedef struct packed {
    logic signed [DATA_W-1:0] origin_real;
    logic signed [DATA_W-1:0] origin_imag;
    logic signed [DATA_W-1:0] step_real;
    logic signed [DATA_W-1:0] step_imag;
    logic [COUNT_W-1:0]       iteration_limit;
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
  } cfg_t;

endpackage

>>> rtl/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time block: configuration registers and iteration core.
// An out-of-image pixel gives its result the cycle after start is taken, busy staying low.
// Otherwise c is formed in C_RE, C_IM and LOAD, then the updates run (none when the limit is
// zero); each update steps through SQ_R, SQ_I, CROSS and UPDATE around one multiplier.
// One pixel at a time: busy stays high until the result strobe; out_valid lasts one cycle.
// Synchronous active-low reset loads the register defaults and returns the sequencer to idle.
module mandelbrot_escape_time_top #(
  parameter int FRAC_BITS  = 28,
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         in_pixel_col,
  input  logic [COORD_BITS-1:0]         in_pixel_row,
  output logic                          out_valid,
  output logic [mbet_pkg::COUNT_W-1:0]  out_iteration_count,
  output logic                          out_escaped,
  output logic                          out_coord_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbet_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::DATA_W-1:0]   cfg_data
);

  mbet_pkg::cfg_t cfg;

  mbet_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbet_core #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .start           (start),
    .busy            (busy),
    .pixel_col       (in_pixel_col),
    .pixel_row       (in_pixel_row),
    .res_valid       (out_valid),
    .res_count       (out_iteration_count),
    .res_escaped     (out_escaped),
    .res_coord_error (out_coord_error)
  );

endmodule

>>> rtl/mbet_cfg.sv
// Configuration register file for the Mandelbrot escape-time block.
module mbet_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbet_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::DATA_W-1:0]   cfg_data,
  output mbet_pkg::cfg_t                cfg
);

  mbet_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_real     <= mbet_pkg::RST_ORIGIN_REAL;
      cfg_r.origin_imag     <= mbet_pkg::RST_ORIGIN_IMAG;
      cfg_r.step_real       <= mbet_pkg::RST_STEP_REAL;
      cfg_r.step_imag       <= mbet_pkg::RST_STEP_IMAG;
      cfg_r.iteration_limit <= mbet_pkg::RST_ITER_LIMIT;
      cfg_r.image_width     <= mbet_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height    <= mbet_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbet_pkg::REG_ORIGIN_REAL:     cfg_r.origin_real <= $signed(cfg_data);
        mbet_pkg::REG_ORIGIN_IMAG:     cfg_r.origin_imag <= $signed(cfg_data);
        mbet_pkg::REG_STEP_REAL:       cfg_r.step_real <= $signed(cfg_data);
        mbet_pkg::REG_STEP_IMAG:       cfg_r.step_imag <= $signed(cfg_data);
        mbet_pkg::REG_ITERATION_LIMIT: cfg_r.iteration_limit <= cfg_data[mbet_pkg::COUNT_W-1:0];
        mbet_pkg::REG_IMAGE_WIDTH:     cfg_r.image_width <= cfg_data[mbet_pkg::DIM_W-1:0];
        mbet_pkg::REG_IMAGE_HEIGHT:    cfg_r.image_height <= cfg_data[mbet_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/mbet_mul.sv
// Shared signed 32x32 multiplier with a registered product.
module mbet_mul (
  input  logic                                clk,
  input  logic signed [mbet_pkg::DATA_W-1:0]  op_a,
  input  logic signed [mbet_pkg::DATA_W-1:0]  op_b,
  output logic signed [mbet_pkg::PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

>>> rtl/mbet_core.sv
// Sequencer and datapath that run the escape-time iteration on the shared multiplier.
module mbet_core #(
  parameter int FRAC_BITS  = 28,
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbet_pkg::cfg_t                cfg,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         pixel_col,
  input  logic [COORD_BITS-1:0]         pixel_row,
  output logic                          res_valid,
  output logic [mbet_pkg::COUNT_W-1:0]  res_count,
  output logic                          res_escaped,
  output logic                          res_coord_error
);

  localparam int DW = mbet_pkg::DATA_W;
  localparam int PW = mbet_pkg::PROD_W;
  localparam int CW = mbet_pkg::COUNT_W;
  localparam int XW = (COORD_BITS > mbet_pkg::DIM_W) ? COORD_BITS : mbet_pkg::DIM_W;
  localparam bit HAVE_LIM = (2 * FRAC_BITS + 2) < 63;
  localparam logic [PW-1:0] LIM4 = HAVE_LIM ? (64'd1 << (2 * FRAC_BITS + 2)) : 64'd0;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_C_RE   = 8'b0000_0010,
    ST_C_IM   = 8'b0000_0100,
    ST_LOAD   = 8'b0000_1000,
    ST_SQ_R   = 8'b0001_0000,
    ST_SQ_I   = 8'b0010_0000,
    ST_CROSS  = 8'b0100_0000,
    ST_UPDATE = 8'b1000_0000
  } state_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [DW-1:0] res;
    if (v > $signed(64'sh0000_0000_7FFF_FFFF)) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < $signed(64'shFFFF_FFFF_8000_0000)) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[DW-1:0];
    end
    return res;
  endfunction

  function automatic logic fits32(input logic signed [PW-1:0] v);
    return (v[PW-1:DW-1] == '0) || (v[PW-1:DW-1] == '1);
  endfunction

  state_t                 state_r, state_nxt;
  logic [COORD_BITS-1:0]  col_r, col_nxt;
  logic [XW-1:0]          roff_r, roff_nxt;
  logic signed [DW-1:0]   cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [DW-1:0]   zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [PW-1:0]   sqr_r, sqr_nxt, sqi_r, sqi_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   chk_r, chk_nxt;
  logic                   vld_r, vld_nxt;
  logic [CW-1:0]          cnt_out_r, cnt_out_nxt;
  logic                   esc_r, esc_nxt, err_r, err_nxt;

  logic signed [DW-1:0]   op_a, op_b;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   diff, nr, ni;
  logic [PW-1:0]          norm;
  logic                   over;
  logic [CW-1:0]          cnt_eff;
  logic                   out_of_image;
  logic [XW-1:0]          roff_in;

  mbet_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  assign busy            = (state_r != ST_IDLE);
  assign res_valid       = vld_r;
  assign res_count       = cnt_out_r;
  assign res_escaped     = esc_r;
  assign res_coord_error = err_r;

  assign out_of_image = (XW'(pixel_col) >= XW'(cfg.image_width)) ||
                        (XW'(pixel_row) >= XW'(cfg.image_height));
  assign roff_in      = XW'(cfg.image_height) - XW'(pixel_row) - XW'(1);

  assign diff    = sqr_r - sqi_r;
  assign nr      = (diff >>> FRAC_BITS) + PW'(cr_r);
  assign ni      = (prod >>> (FRAC_BITS - 1)) + PW'(ci_r);
  assign norm    = $unsigned(sqr_r) + $unsigned(sqi_r);
  assign over    = HAVE_LIM && chk_r && (norm > LIM4);
  assign cnt_eff = cnt_r + CW'(chk_r);

  always_comb begin
    case (state_r)
      ST_C_RE: begin
        op_a = cfg.step_real;
        op_b = $signed(DW'(col_r));
      end
      ST_C_IM: begin
        op_a = cfg.step_imag;
        op_b = $signed(DW'(roff_r));
      end
      ST_SQ_R: begin
        op_a = zr_r;
        op_b = zr_r;
      end
      ST_SQ_I: begin
        op_a = zi_r;
        op_b = zi_r;
      end
      default: begin
        op_a = zr_r;
        op_b = zi_r;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    roff_nxt    = roff_r;
    cr_nxt      = cr_r;
    ci_nxt      = ci_r;
    zr_nxt      = zr_r;
    zi_nxt      = zi_r;
    sqr_nxt     = sqr_r;
    sqi_nxt     = sqi_r;
    cnt_nxt     = cnt_r;
    chk_nxt     = chk_r;
    vld_nxt     = 1'b0;
    cnt_out_nxt = cnt_out_r;
    esc_nxt     = esc_r;
    err_nxt     = err_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (out_of_image) begin
            vld_nxt     = 1'b1;
            cnt_out_nxt = '0;
            esc_nxt     = 1'b0;
            err_nxt     = 1'b1;
          end else begin
            col_nxt   = pixel_col;
            roff_nxt  = roff_in;
            state_nxt = ST_C_RE;
          end
        end
      end
      ST_C_RE: begin
        state_nxt = ST_C_IM;
      end
      ST_C_IM: begin
        cr_nxt    = sat32(PW'(cfg.origin_real) + prod);
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        ci_nxt  = sat32(PW'(cfg.origin_imag) + prod);
        zr_nxt  = '0;
        zi_nxt  = '0;
        cnt_nxt = '0;
        chk_nxt = 1'b0;
        if (cfg.iteration_limit == '0) begin
          vld_nxt     = 1'b1;
          cnt_out_nxt = '0;
          esc_nxt     = 1'b0;
          err_nxt     = 1'b0;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_SQ_R;
        end
      end
      ST_SQ_R: begin
        state_nxt = ST_SQ_I;
      end
      ST_SQ_I: begin
        sqr_nxt   = prod;
        state_nxt = ST_CROSS;
      end
      ST_CROSS: begin
        sqi_nxt   = prod;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (over) begin
          vld_nxt     = 1'b1;
          cnt_out_nxt = cnt_r;
          esc_nxt     = 1'b1;
          err_nxt     = 1'b0;
          state_nxt   = ST_IDLE;
        end else if (cnt_eff == cfg.iteration_limit) begin
          vld_nxt     = 1'b1;
          cnt_out_nxt = cnt_eff;
          esc_nxt     = 1'b0;
          err_nxt     = 1'b0;
          state_nxt   = ST_IDLE;
        end else if (!fits32(nr) || !fits32(ni)) begin
          vld_nxt     = 1'b1;
          cnt_out_nxt = cnt_eff;
          esc_nxt     = 1'b1;
          err_nxt     = 1'b0;
          state_nxt   = ST_IDLE;
        end else begin
          zr_nxt    = nr[DW-1:0];
          zi_nxt    = ni[DW-1:0];
          cnt_nxt   = cnt_eff;
          chk_nxt   = 1'b1;
          state_nxt = ST_SQ_R;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
      chk_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      chk_r   <= chk_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    roff_r    <= roff_nxt;
    cr_r      <= cr_nxt;
    ci_r      <= ci_nxt;
    zr_r      <= zr_nxt;
    zi_r      <= zi_nxt;
    sqr_r     <= sqr_nxt;
    sqi_r     <= sqi_nxt;
    cnt_out_r <= cnt_out_nxt;
    esc_r     <= esc_nxt;
    err_r     <= err_nxt;
  end

endmodule
